// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the quadratic root block.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ----- rtl/qri_pkg.sv -----
// Shared constants and side-band types for the quadratic root block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package qri_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int Q_W           = 32;
	localparam int TDATA_IN_W    = 5 * Q_W;
	localparam int DISC_W        = 66;   // discriminant, always below 2^66
	localparam int SQ_STEPS      = DISC_W / 2;
	localparam int ROOT_W        = SQ_STEPS;
	localparam int REM_W         = ROOT_W + 2;
	localparam int SROOT_W       = ROOT_W + 1;   // after rounding
	localparam int NUM_W         = SROOT_W + 2;  // signed -b +/- sqrt
	localparam int MAG_W         = NUM_W - 1;
	localparam int DIV_W         = Q_W + 1;      // divisor 2|a|

	localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
	localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

	typedef struct packed {
		logic                  ok;
		logic                  a_neg;
		logic [Q_W-1:0]        a_mag;
		logic signed [Q_W-1:0] b;
		logic signed [Q_W-1:0] lo;
		logic signed [Q_W-1:0] hi;
	} side_t;

	typedef struct packed {
		logic                  ok;
		logic [1:0]            neg;
		logic [DIV_W-1:0]      dvsr;
		logic signed [Q_W-1:0] lo;
		logic signed [Q_W-1:0] hi;
	} div_side_t;

endpackage

// ----- rtl/qri_sqrt_cell.sv -----
// One digit step of the integer square root chain.
// Depends on qri_pkg.
`timescale 1ns / 1ps

module qri_sqrt_cell import qri_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [DISC_W-1:0] in_rad,
	input  logic [ROOT_W-1:0] in_root,
	input  logic [REM_W-1:0]  in_rem,
	input  side_t             in_side,
	output logic              out_valid,
	output logic [DISC_W-1:0] out_rad,
	output logic [ROOT_W-1:0] out_root,
	output logic [REM_W-1:0]  out_rem,
	output side_t             out_side
);

	logic [REM_W+1:0] t, trial, diff;
	logic             take;
	logic             valid_q;
	logic [DISC_W-1:0] rad_q;
	logic [ROOT_W-1:0] root_q;
	logic [REM_W-1:0]  rem_q;
	side_t             side_q;

	always_comb begin
		t     = {in_rem, in_rad[DISC_W-1 -: 2]};
		trial = {2'b00, in_root, 2'b01};
		diff  = t - trial;
		take  = (t >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_q  <= {in_rad[DISC_W-3:0], 2'b00};
			root_q <= {in_root[ROOT_W-2:0], take};
			rem_q  <= take ? diff[REM_W-1:0] : t[REM_W-1:0];
			side_q <= in_side;
		end
	end

	assign out_valid = valid_q;
	assign out_rad   = rad_q;
	assign out_root  = root_q;
	assign out_rem   = rem_q;
	assign out_side  = side_q;

endmodule

// ----- rtl/qri_div_cell.sv -----
// One quotient-bit step for both root dividers (restoring division).
// Depends on qri_pkg.
`timescale 1ns / 1ps

module qri_div_cell import qri_pkg::*; #(
	parameter int NW = MAG_W + FRAC_BITS_DEF + 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [1:0][DIV_W-1:0]     in_rem,
	input  logic [1:0][NW-1:0]        in_nq,
	input  div_side_t                 in_side,
	output logic                      out_valid,
	output logic [1:0][DIV_W-1:0]     out_rem,
	output logic [1:0][NW-1:0]        out_nq,
	output div_side_t                 out_side
);

	logic [1:0][DIV_W:0]   t, diff;
	logic [1:0]            take;
	logic                  valid_q;
	logic [1:0][DIV_W-1:0] rem_q;
	logic [1:0][NW-1:0]    nq_q;
	div_side_t             side_q;

	// dividend bits leave at the top of nq while quotient bits enter at the bottom
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			t[l]    = {in_rem[l], in_nq[l][NW-1]};
			diff[l] = t[l] - {1'b0, in_side.dvsr};
			take[l] = (t[l] >= {1'b0, in_side.dvsr});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 2; l++) begin
				rem_q[l] <= take[l] ? diff[l][DIV_W-1:0] : t[l][DIV_W-1:0];
				nq_q[l]  <= {in_nq[l][NW-2:0], take[l]};
			end
			side_q <= in_side;
		end
	end

	assign out_valid = valid_q;
	assign out_rem   = rem_q;
	assign out_nq    = nq_q;
	assign out_side  = side_q;

endmodule

// ----- rtl/quadratic_root_in_range.sv -----
// Pipeline: 43 + NW register stages, NW = FRAC_BITS + 36: 4 front stages,
// 33 square-root cells, 3 setup stages, NW divider cells, 2 final stages and
// the output register.
// Throughput: one request per cycle; the whole pipeline holds only when the
// output register is full, not taken, and the last stage carries a result.
// Reset (arst_n low, asynchronous) clears all valid flags; data is not reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module quadratic_root_in_range import qri_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// coef_a, coef_b, coef_c, range_low, range_high (from bit 0 up)
	input  logic [TDATA_IN_W-1:0] s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// root
	output logic [Q_W-1:0]        m_tdata,
	// found
	output logic                  m_tuser
);

	localparam int NW = MAG_W + FRAC_BITS + 1;

	logic en;

	// front: input, magnitudes, products, discriminant
	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [Q_W-1:0] a_s1, b_s1, c_s1, lo_s1, hi_s1;
	logic [Q_W-1:0] a_mag_s2, b_mag_s2, c_mag_s2;
	logic a_neg_s2, sub_s2;
	logic signed [Q_W-1:0] b_s2, lo_s2, hi_s2;
	logic [2*Q_W-1:0] bb_s3, m_s3;
	logic a_neg_s3, sub_s3;
	logic [Q_W-1:0] a_mag_s3;
	logic signed [Q_W-1:0] b_s3, lo_s3, hi_s3;
	logic [DISC_W:0] disc;
	logic [DISC_W-1:0] rad_s4;
	side_t side_s4;

	always_comb begin
		if (sub_s3) begin
			disc = {3'b000, bb_s3} - {1'b0, m_s3, 2'b00};
		end else begin
			disc = {3'b000, bb_s3} + {1'b0, m_s3, 2'b00};
		end
	end

	// square-root chain
	logic              sq_v    [SQ_STEPS+1];
	logic [DISC_W-1:0] sq_rad  [SQ_STEPS+1];
	logic [ROOT_W-1:0] sq_root [SQ_STEPS+1];
	logic [REM_W-1:0]  sq_rem  [SQ_STEPS+1];
	side_t             sq_side [SQ_STEPS+1];

	assign sq_v[0]    = v_s4;
	assign sq_rad[0]  = rad_s4;
	assign sq_root[0] = '0;
	assign sq_rem[0]  = '0;
	assign sq_side[0] = side_s4;

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
		qri_sqrt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (sq_v[k]),
			.in_rad    (sq_rad[k]),
			.in_root   (sq_root[k]),
			.in_rem    (sq_rem[k]),
			.in_side   (sq_side[k]),
			.out_valid (sq_v[k+1]),
			.out_rad   (sq_rad[k+1]),
			.out_root  (sq_root[k+1]),
			.out_rem   (sq_rem[k+1]),
			.out_side  (sq_side[k+1])
		);
	end

	// setup: round, numerators, dividends
	logic v_s5, v_s6, v_s7;
	logic [SROOT_W-1:0] s_s5;
	side_t side_s5, side_s6;
	logic signed [NUM_W-1:0] n1, n2;
	logic [MAG_W-1:0] mag1_s6, mag2_s6;
	logic neg1_s6, neg2_s6;
	logic [1:0][NW-1:0] nq_s7;
	div_side_t dside_s7;

	always_comb begin
		n1 = -{{(NUM_W-Q_W){side_s5.b[Q_W-1]}}, side_s5.b} - {2'b00, s_s5};
		n2 = -{{(NUM_W-Q_W){side_s5.b[Q_W-1]}}, side_s5.b} + {2'b00, s_s5};
	end

	// divider chain
	logic                  dv_v    [NW+1];
	logic [1:0][DIV_W-1:0] dv_rem  [NW+1];
	logic [1:0][NW-1:0]    dv_nq   [NW+1];
	div_side_t             dv_side [NW+1];

	assign dv_v[0]    = v_s7;
	assign dv_rem[0]  = '0;
	assign dv_nq[0]   = nq_s7;
	assign dv_side[0] = dside_s7;

	for (genvar k = 0; k < NW; k++) begin : g_div
		qri_div_cell #(.NW(NW)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (dv_v[k]),
			.in_rem    (dv_rem[k]),
			.in_nq     (dv_nq[k]),
			.in_side   (dv_side[k]),
			.out_valid (dv_v[k+1]),
			.out_rem   (dv_rem[k+1]),
			.out_nq    (dv_nq[k+1]),
			.out_side  (dv_side[k+1])
		);
	end

	// final: saturate, order, select
	logic v_s8, v_s9;
	logic [1:0][Q_W-1:0] sat;
	logic signed [Q_W-1:0] r1_s8, r2_s8, rlo_s9, rhi_s9;
	logic ok_s8, ok_s9;
	logic signed [Q_W-1:0] lo_s8, hi_s8, lo_s9, hi_s9;
	logic in1, in2;
	logic out_v_q, found_q;
	logic [Q_W-1:0] root_q;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			if (dv_side[NW].neg[l] && (|dv_nq[NW][l])) begin
				if ((|dv_nq[NW][l][NW-1:Q_W]) ||
					(dv_nq[NW][l][Q_W-1] && (|dv_nq[NW][l][Q_W-2:0]))) begin
					sat[l] = Q_MIN;
				end else begin
					sat[l] = -dv_nq[NW][l][Q_W-1:0];
				end
			end else if (|dv_nq[NW][l][NW-1:Q_W-1]) begin
				sat[l] = Q_MAX;
			end else begin
				sat[l] = dv_nq[NW][l][Q_W-1:0];
			end
		end
		in1 = (rlo_s9 > lo_s9) && (rlo_s9 < hi_s9);
		in2 = (rhi_s9 > lo_s9) && (rhi_s9 < hi_s9);
	end

	assign en = !out_v_q || m_tready || !v_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (en) begin
				v_s1 <= s_tvalid;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				v_s4 <= v_s3;
				v_s5 <= sq_v[SQ_STEPS];
				v_s6 <= v_s5;
				v_s7 <= v_s6;
				v_s8 <= dv_v[NW];
				v_s9 <= v_s8;
			end
			if (en && v_s9) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= s_tdata[Q_W-1:0];
			b_s1  <= s_tdata[2*Q_W-1:Q_W];
			c_s1  <= s_tdata[3*Q_W-1:2*Q_W];
			lo_s1 <= s_tdata[4*Q_W-1:3*Q_W];
			hi_s1 <= s_tdata[5*Q_W-1:4*Q_W];

			a_mag_s2 <= a_s1[Q_W-1] ? -a_s1 : a_s1;
			b_mag_s2 <= b_s1[Q_W-1] ? -b_s1 : b_s1;
			c_mag_s2 <= c_s1[Q_W-1] ? -c_s1 : c_s1;
			a_neg_s2 <= a_s1[Q_W-1];
			// 4ac > 0 only when a and c share a sign and c is nonzero
			sub_s2   <= (c_s1 != '0) && (a_s1[Q_W-1] == c_s1[Q_W-1]);
			b_s2     <= b_s1;
			lo_s2    <= lo_s1;
			hi_s2    <= hi_s1;

			bb_s3    <= b_mag_s2 * b_mag_s2;
			m_s3     <= a_mag_s2 * c_mag_s2;
			a_neg_s3 <= a_neg_s2;
			sub_s3   <= sub_s2;
			a_mag_s3 <= a_mag_s2;
			b_s3     <= b_s2;
			lo_s3    <= lo_s2;
			hi_s3    <= hi_s2;

			rad_s4        <= disc[DISC_W-1:0];
			side_s4.ok    <= (a_mag_s3 != '0) && !disc[DISC_W];
			side_s4.a_neg <= a_neg_s3;
			side_s4.a_mag <= a_mag_s3;
			side_s4.b     <= b_s3;
			side_s4.lo    <= lo_s3;
			side_s4.hi    <= hi_s3;

			// round to nearest: remainder above root means bump
			s_s5    <= {1'b0, sq_root[SQ_STEPS]} +
				SROOT_W'(sq_rem[SQ_STEPS] > {2'b00, sq_root[SQ_STEPS]});
			side_s5 <= sq_side[SQ_STEPS];

			mag1_s6 <= n1[NUM_W-1] ? MAG_W'(-n1) : MAG_W'(n1);
			mag2_s6 <= n2[NUM_W-1] ? MAG_W'(-n2) : MAG_W'(n2);
			neg1_s6 <= n1[NUM_W-1] != side_s5.a_neg;
			neg2_s6 <= n2[NUM_W-1] != side_s5.a_neg;
			side_s6 <= side_s5;

			// (|n| << F) + |a|, divided by 2|a| gives the rounded quotient
			nq_s7[0] <= {1'b0, mag1_s6, {FRAC_BITS{1'b0}}} +
				{{(NW-Q_W){1'b0}}, side_s6.a_mag};
			nq_s7[1] <= {1'b0, mag2_s6, {FRAC_BITS{1'b0}}} +
				{{(NW-Q_W){1'b0}}, side_s6.a_mag};
			dside_s7.ok   <= side_s6.ok;
			dside_s7.neg  <= {neg2_s6, neg1_s6};
			dside_s7.dvsr <= {side_s6.a_mag, 1'b0};
			dside_s7.lo   <= side_s6.lo;
			dside_s7.hi   <= side_s6.hi;

			r1_s8 <= sat[0];
			r2_s8 <= sat[1];
			ok_s8 <= dv_side[NW].ok;
			lo_s8 <= dv_side[NW].lo;
			hi_s8 <= dv_side[NW].hi;

			rlo_s9 <= (r1_s8 > r2_s8) ? r2_s8 : r1_s8;
			rhi_s9 <= (r1_s8 > r2_s8) ? r1_s8 : r2_s8;
			ok_s9  <= ok_s8;
			lo_s9  <= lo_s8;
			hi_s9  <= hi_s8;
		end
		if (en && v_s9) begin
			found_q <= ok_s9 && (in1 || in2);
			if (ok_s9 && in1) begin
				root_q <= rlo_s9;
			end else if (ok_s9 && in2) begin
				root_q <= rhi_s9;
			end else begin
				root_q <= '0;
			end
		end
	end

	assign s_tready = en;
	assign m_tvalid = out_v_q;
	assign m_tdata  = root_q;
	assign m_tuser  = found_q;

	`ASSERT_HOLDS(a_stall_cause, clk, arst_n, !s_tready |-> (m_tvalid && !m_tready && v_s9), "pipeline held without a blocked result")
	`ASSERT_NEVER(a_empty_root, clk, arst_n, m_tvalid && !m_tuser && (m_tdata != '0), "nonzero root without found")
	`ASSERT_HOLDS(a_roots_ordered, clk, arst_n, v_s9 |-> (rlo_s9 <= rhi_s9), "roots out of order")

endmodule
